// ===== rtl/core/ium_pkg.sv =====
// ----------------------------------------------------------------------------
// ium_pkg
// Shared types and constants for the interval union merger.
// ----------------------------------------------------------------------------
package ium_pkg;

    localparam int FIELD_W     = 64;
    localparam int IN_TDATA_W  = 2 * FIELD_W;
    localparam int OUT_TDATA_W = 3 * FIELD_W;

    // result queue: one entry drains per cycle while the receiver is ready, up to two are written per item
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [FIELD_W-1:0] merged_start;
        logic [FIELD_W-1:0] merged_end;
        logic [FIELD_W-1:0] covered_total;
        logic               list_done;
        logic               empty_list;
    } t_result;

    // results handed from the merge stage to the queue for one item
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ===== rtl/core/ium_merge.sv =====
// ----------------------------------------------------------------------------
// ium_merge
// Input register plus open-interval state; merges one item per cycle while
// the queue has room and produces zero, one or two results.
// ----------------------------------------------------------------------------
module ium_merge #(
    parameter int TIME_WIDTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [ium_pkg::FIELD_W-1:0] i_start,
    input  logic [ium_pkg::FIELD_W-1:0] i_end,
    input  logic                        i_skip,
    input  logic                        i_last,
    input  logic                        i_room,
    output logic                        o_ready,
    output ium_pkg::t_push              o_push
);
    import ium_pkg::*;

    logic                  r_in_vld;
    logic [TIME_WIDTH-1:0] r_s;
    logic [TIME_WIDTH-1:0] r_e;
    logic                  r_skip;
    logic                  r_last;

    logic                  r_have;
    logic [TIME_WIDTH-1:0] r_open_start;
    logic [TIME_WIDTH-1:0] r_open_end;
    logic [FIELD_W-1:0]    r_total;

    logic                  n_have;
    logic [TIME_WIDTH-1:0] n_open_start;
    logic [TIME_WIDTH-1:0] n_open_end;
    logic [FIELD_W-1:0]    n_total;

    logic                  adv;
    logic [TIME_WIDTH-1:0] e_eff;
    logic [TIME_WIDTH-1:0] sub_b;
    logic [TIME_WIDTH-1:0] diff;
    logic                  close_open;
    logic                  new_open;
    logic                  extend;
    t_result               res_close;
    t_result               res_last;

    assign adv     = r_in_vld && i_room;
    assign o_ready = !r_in_vld || adv;

    always_comb begin
        // reversed interval collapses to zero length at its start
        e_eff      = (r_e < r_s) ? r_s : r_e;
        close_open = !r_skip && r_have && (r_open_end < r_s);
        new_open   = !r_skip && (!r_have || close_open);
        extend     = !r_skip && r_have && !close_open && (r_open_end < e_eff);
        sub_b      = new_open ? r_s : r_open_end;
        diff       = e_eff - sub_b;

        n_have       = r_have || new_open;
        n_open_start = new_open ? r_s : r_open_start;
        n_open_end   = (new_open || extend) ? e_eff : r_open_end;
        n_total      = (new_open || extend) ? r_total + FIELD_W'(diff) : r_total;

        res_close.merged_start  = FIELD_W'(r_open_start);
        res_close.merged_end    = FIELD_W'(r_open_end);
        res_close.covered_total = r_total;
        res_close.list_done     = 1'b0;
        res_close.empty_list    = 1'b0;

        if (n_have) begin
            res_last.merged_start  = FIELD_W'(n_open_start);
            res_last.merged_end    = FIELD_W'(n_open_end);
            res_last.covered_total = n_total;
            res_last.empty_list    = 1'b0;
        end else begin
            res_last.merged_start  = '0;
            res_last.merged_end    = '0;
            res_last.covered_total = '0;
            res_last.empty_list    = 1'b1;
        end
        res_last.list_done = 1'b1;

        o_push.cnt  = adv ? (2'(close_open) + 2'(r_last)) : 2'd0;
        o_push.res0 = close_open ? res_close : res_last;
        o_push.res1 = res_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s    <= i_start[TIME_WIDTH-1:0];
            r_e    <= i_end[TIME_WIDTH-1:0];
            r_skip <= i_skip;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have       <= 1'b0;
            r_open_start <= '0;
            r_open_end   <= '0;
            r_total      <= '0;
        end else if (adv) begin
            if (r_last) begin
                r_have       <= 1'b0;
                r_open_start <= '0;
                r_open_end   <= '0;
                r_total      <= '0;
            end else begin
                r_have       <= n_have;
                r_open_start <= n_open_start;
                r_open_end   <= n_open_end;
                r_total      <= n_total;
            end
        end
    end

endmodule

// ===== rtl/core/ium_out_queue.sv =====
// ----------------------------------------------------------------------------
// ium_out_queue
// Small result queue: takes up to two results a cycle, drains one when popped.
// ----------------------------------------------------------------------------
module ium_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ium_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_vld,
    output ium_pkg::t_result o_res
);
    import ium_pkg::*;

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic                 pop_ok;
    logic [Q_PTR_W-1:0]   wr_ptr1;

    assign o_vld   = (r_cnt != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && o_vld;
    assign o_room  = (r_cnt <= Q_CNT_W'(Q_DEPTH - 2));
    assign wr_ptr1 = r_wr_ptr + Q_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (i_push.cnt != 2'd0 && Q_PTR_W'(i) == r_wr_ptr) begin
                r_mem[i] <= i_push.res0;
            end else if (i_push.cnt == 2'd2 && Q_PTR_W'(i) == wr_ptr1) begin
                r_mem[i] <= i_push.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_PTR_W'(i_push.cnt);
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push.cnt) - Q_CNT_W'(pop_ok);
        end
    end

endmodule

// ===== rtl/core/interval_union_merge.sv =====
// ----------------------------------------------------------------------------
// interval_union_merge
// Builds the union of a start-ordered list of time intervals.
// ----------------------------------------------------------------------------
// Input stream: one interval per item; tdata = start, end; tuser marks an
// interval to skip; tlast marks the last item of a list, which flushes the
// open interval with its covered total (or an empty marker) and clears state.
// Output stream: one merged interval per item; tdata = start, end, total;
// tlast marks the final result of a list; tuser flags an empty list.
// An accepted item waits in the input register; its results are then written
// to the result queue, which offers them on the output stream.
// Throughput: one item per cycle while the queue has room. An item that
// both closes an interval and ends its list yields two results; the single
// output port drains one per cycle, so a four-entry queue absorbs the burst.
// s_axis_tready drops while an item waits in the input register and the
// queue lacks room for two results, i.e. when the receiver stalls; nothing
// is lost. Reset clears the open interval, the total and the queue.
// ----------------------------------------------------------------------------
module interval_union_merge #(
    parameter int TIME_WIDTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [63:0] start_time, [127:64] end_time
    input  logic [ium_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] filtered_out
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [63:0] merged_start, [127:64] merged_end, [191:128] covered_total
    output logic [ium_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] empty_list
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import ium_pkg::*;

    logic    room;
    t_push   push;
    t_result res;

    ium_merge #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .i_start (s_axis_tdata[FIELD_W-1:0]),
        .i_end   (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .i_skip  (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .i_room  (room),
        .o_ready (s_axis_tready),
        .o_push  (push)
    );

    ium_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_room  (room),
        .o_vld   (m_axis_tvalid),
        .o_res   (res)
    );

    assign m_axis_tdata = {res.covered_total, res.merged_end, res.merged_start};
    assign m_axis_tuser = res.empty_list;
    assign m_axis_tlast = res.list_done;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for interval_union_merge. A scoreboard predicts the
// merged intervals and covered totals for every accepted item and compares
// each output item field by field, in order. Stimulus is a directed set of
// corner lists followed by random lists of mostly ordered intervals, run
// under several sender/receiver idle mixes, including one long receiver
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

class union_scoreboard;

    localparam int TW = 64;
    localparam logic [63:0] TIME_MASK = {64{1'b1}} >> (64 - TW);

    bit                span_open;
    logic [63:0]       span_start;
    logic [63:0]       span_end;
    logic [63:0]       covered;
    ium_pkg::t_result  pending_merges[$];
    int                errors;

    function new();
        clear_span();
        errors = 0;
    endfunction

    function void clear_span();
        span_open  = 1'b0;
        span_start = '0;
        span_end   = '0;
        covered    = '0;
    endfunction

    function int pending();
        return pending_merges.size();
    endfunction

    function void push_merge(logic [63:0] s, logic [63:0] e, logic [63:0] tot,
                             logic done, logic empty);
        ium_pkg::t_result r;
        r.merged_start  = s & TIME_MASK;
        r.merged_end    = e & TIME_MASK;
        r.covered_total = tot;
        r.list_done     = done;
        r.empty_list    = empty;
        pending_merges.insert(pending_merges.size(), r);
    endfunction

    // predict the merged intervals caused by one accepted item
    function void note_interval(logic [63:0] start_in, logic [63:0] end_in,
                                logic skip, logic last);
        logic [63:0] s;
        logic [63:0] e;
        s = start_in & TIME_MASK;
        e = end_in & TIME_MASK;
        if (!skip) begin
            if (e < s) e = s;   // reversed interval has zero length
            if (!span_open) begin
                span_open  = 1'b1;
                span_start = s;
                span_end   = e;
                covered    = covered + (e - s);
            end else if (span_end < s) begin
                push_merge(span_start, span_end, covered, 1'b0, 1'b0);
                span_start = s;
                span_end   = e;
                covered    = covered + (e - s);
            end else if (span_end < e) begin
                covered  = covered + (e - span_end);
                span_end = e;
            end
        end
        if (last) begin
            if (span_open)
                push_merge(span_start, span_end, covered, 1'b1, 1'b0);
            else
                push_merge('0, '0, '0, 1'b1, 1'b1);
            clear_span();
        end
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task check_merged(ium_pkg::t_result got);
        ium_pkg::t_result want;
        if (pending_merges.size() == 0) begin
            report($sformatf("unexpected item start=%h end=%h total=%h",
                             got.merged_start, got.merged_end, got.covered_total));
            return;
        end
        want = pending_merges.pop_front();
        if (got.merged_start !== want.merged_start)
            report($sformatf("merged_start got %h want %h",
                             got.merged_start, want.merged_start));
        if (got.merged_end !== want.merged_end)
            report($sformatf("merged_end got %h want %h",
                             got.merged_end, want.merged_end));
        if (got.covered_total !== want.covered_total)
            report($sformatf("covered_total got %h want %h",
                             got.covered_total, want.covered_total));
        if (got.list_done !== want.list_done)
            report($sformatf("list_done got %b want %b",
                             got.list_done, want.list_done));
        if (got.empty_list !== want.empty_list)
            report($sformatf("empty_list got %b want %b",
                             got.empty_list, want.empty_list));
    endtask

endclass

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TIME_W    = 64;
    localparam logic [63:0] ALL_ONES  = {64{1'b1}};
    localparam int          PHASE_LEN = 460;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [63:0] start_time, [127:64] end_time
    logic [ium_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [0] filtered_out
    logic                            s_axis_tuser = 1'b0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [63:0] merged_start, [127:64] merged_end, [191:128] covered_total
    logic [ium_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] empty_list
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;

    union_scoreboard  sb;
    ium_pkg::t_result rx_item;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    bit               hold_request = 1'b0;
    int               hold_left = 0;
    int               items_sent = 0;

    interval_union_merge #(
        .TIME_WIDTH(TIME_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // output side: check accepted items, then pick next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_item.merged_start  = m_axis_tdata[63:0];
            rx_item.merged_end    = m_axis_tdata[127:64];
            rx_item.covered_total = m_axis_tdata[191:128];
            rx_item.list_done     = m_axis_tlast;
            rx_item.empty_list    = m_axis_tuser;
            sb.check_merged(rx_item);
        end
        if (hold_request) begin
            hold_left    = 400;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_interval(logic [63:0] s, logic [63:0] e, logic skip,
                                 logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {e, s};
        s_axis_tuser  <= skip;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_interval(s, e, skip, last);
        items_sent++;
    endtask

    // stop offering and wait for every predicted item to drain
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one list of mostly start-ordered intervals with random spacing
    task automatic random_list();
        int          len;
        int          kind;
        bit          all_skip;
        logic        skip;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] eff_e;
        logic [63:0] cur_s;
        logic [63:0] cur_e;
        kind = $urandom_range(99);
        len = (kind < 80) ? $urandom_range(8, 1) : $urandom_range(20, 9);
        all_skip = ($urandom_range(99) < 5);
        case ($urandom_range(2))
            0:       cur_s = 64'($urandom_range(1000));
            1:       cur_s = rand64();
            default: cur_s = ALL_ONES - 64'($urandom_range(100000));
        endcase
        cur_e = cur_s;
        for (int i = 0; i < len; i++) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                s = cur_e + 64'd1 + 64'($urandom_range(500));
                e = s + 64'($urandom_range(500));
            end else if (kind < 45) begin
                s = cur_e;
                e = s + 64'($urandom_range(300));
            end else if (kind < 65) begin
                s = cur_s + ((cur_e - cur_s) >> $urandom_range(3));
                e = cur_e + 64'($urandom_range(400));
            end else if (kind < 75) begin
                s = cur_s;
                e = cur_s + ((cur_e - cur_s) >> 1);
            end else if (kind < 85) begin
                s = cur_e + 64'($urandom_range(50));
                e = s - 64'd1 - 64'($urandom_range(1000));
            end else if (kind < 92) begin
                s = cur_s - 64'd1 - 64'($urandom_range(100));
                e = s + 64'($urandom_range(2000));
            end else begin
                s = rand64();
                e = rand64();
            end
            skip = all_skip || ($urandom_range(99) < 10);
            send_interval(s, e, skip, i == len - 1);
            if (!skip) begin
                eff_e = (e < s) ? s : e;
                if (s > cur_e) begin
                    cur_s = s;
                    cur_e = eff_e;
                end else if (eff_e > cur_e) begin
                    cur_e = eff_e;
                end
            end
        end
    endtask

    task automatic random_phase(int send_pct, int rx_pct, bit long_hold);
        int target;
        target        = items_sent + PHASE_LEN;
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        if (long_hold) hold_request = 1'b1;
        while (items_sent < target) random_list();
        drain();
    endtask

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: only a filtered last item
        send_interval(64'd0, 64'd0, 1'b1, 1'b1);
        // full-range single interval
        send_interval(64'd0, ALL_ONES, 1'b0, 1'b1);
        // touching, contained, reversed, unordered, filtered last
        send_interval(64'd0, 64'd10, 1'b0, 1'b0);
        send_interval(64'd10, 64'd20, 1'b0, 1'b0);
        send_interval(64'd5, 64'd15, 1'b0, 1'b0);
        send_interval(64'd30, 64'd25, 1'b0, 1'b0);
        send_interval(64'd2, 64'd40, 1'b0, 1'b0);
        send_interval(64'd100, 64'd110, 1'b1, 1'b1);
        // total climbs to near 2^64 without wrapping
        send_interval(64'd1000, 64'd2000, 1'b0, 1'b0);
        send_interval(64'd5000, 64'd6000, 1'b0, 1'b0);
        send_interval(64'd0, ALL_ONES, 1'b0, 1'b1);
        // disjoint last item gives two items, top of range
        send_interval(ALL_ONES - 5, ALL_ONES - 5, 1'b0, 1'b0);
        send_interval(ALL_ONES, 64'd0, 1'b1, 1'b0);
        send_interval(ALL_ONES, ALL_ONES, 1'b0, 1'b1);
        // alternating bit patterns, reversed then ordered
        send_interval(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 1'b1);
        send_interval(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1);
        drain();

        random_phase(0, 0, 1'b0);
        random_phase(67, 0, 1'b0);
        random_phase(0, 67, 1'b0);
        random_phase(7, 7, 1'b1);

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
